// ----- rtl/dlbc_pkg.sv -----
// Shared types and constants for the degree-limited bipartite check unit.
// No dependencies.
`default_nettype none

package dlbc_pkg;

    // Width of an endpoint field on the input channel
    localparam int C_END_W     = 10;
    // Default node capacity
    localparam int C_MAX_NODES = 1024;
    // Color code of a node not reached yet
    localparam logic [1:0] C_UNCOLOURED = 2'd3;

    // Reason for a negative answer
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_DEGREE = 2'd1,
        CAUSE_ODD    = 2'd2,
        CAUSE_RANGE  = 2'd3
    } t_cause;

    // Answer for one edge set
    typedef struct packed {
        logic   splittable;
        t_cause cause;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/dlbc_if.sv -----
// Valid/ready channel interfaces for the edge input and the answer output.
// Depends on dlbc_pkg.
`default_nettype none

interface dlbc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dlbc_pkg::C_END_W-1:0]  end_a;
    logic [dlbc_pkg::C_END_W-1:0]  end_b;
    logic                          last_edge;

    modport source (output valid, end_a, end_b, last_edge, input ready);
    modport sink   (input valid, end_a, end_b, last_edge, output ready);
endinterface

interface dlbc_out_if;
    logic       valid;
    logic       ready;
    logic       splittable;
    logic [1:0] fail_cause;

    modport source (output valid, splittable, fail_cause, input ready);
    modport sink   (input valid, splittable, fail_cause, output ready);
endinterface

`default_nettype wire

// ----- rtl/degree_limited_bipartite_check_unit.sv -----
// Top level of the degree-limited bipartite check unit.
// Depends on dlbc_pkg, dlbc_if, dlbc_ram and dlbc_ctrl.
//
// Usage:
//   i_in carries one undirected edge per request (end_a, end_b, last_edge).
//   The set has as many nodes as edges. o_out carries one answer per set,
//   given after the request marked last_edge: splittable and fail_cause
//   (0 none, 1 degree above two, 2 odd cycle, 3 index or count out of range).
// Sequence:
//   Each edge passes through accept, read-modify-write of node a, then of
//   node b in the node RAM (one read and one write port); a self-loop skips
//   the node b step. The last edge adds a decision step and, when range and
//   degrees are fine, a breadth-first walk, all paced by the single node RAM
//   read port.
// Reset and clearing:
//   After reset a clearing pass writes every node entry with i_in.ready
//   low. After each answer a pass clears nodes 0 up to the larger of the
//   highest endpoint and the set's last node (one per cycle).
// Stalls:
//   The answer sits in an output register until taken; the next set's edges
//   load meanwhile, and only its answer waits while o_out is stalled.
`default_nettype none

module degree_limited_bipartite_check_unit #(
    parameter int MAX_NODES = dlbc_pkg::C_MAX_NODES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dlbc_in_if.sink       i_in,
    dlbc_out_if.source    o_out
);

    import dlbc_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int EW = 2 * IW + 4;

    logic          w_in_ready;
    logic          w_done;
    t_result       w_result;
    logic          w_nd_wr_en, w_q_wr_en;
    logic [IW-1:0] w_nd_wr_addr, w_nd_rd_addr, w_q_wr_addr, w_q_rd_addr;
    logic [EW-1:0] w_nd_wr_data, w_nd_rd_data;
    logic [IW-1:0] w_q_wr_data, w_q_rd_data;
    logic          r_out_valid;
    t_result       r_out;

    // node RAM: degree, color and two neighbor slots per node
    dlbc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES), .AW(IW)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_nd_wr_en),
        .i_wr_addr (w_nd_wr_addr),
        .i_wr_data (w_nd_wr_data),
        .i_rd_addr (w_nd_rd_addr),
        .o_rd_data (w_nd_rd_data)
    );

    // visit queue for the walk
    dlbc_ram #(.WIDTH(IW), .DEPTH(MAX_NODES), .AW(IW)) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_wr_en),
        .i_wr_addr (w_q_wr_addr),
        .i_wr_data (w_q_wr_data),
        .i_rd_addr (w_q_rd_addr),
        .o_rd_data (w_q_rd_data)
    );

    dlbc_ctrl #(.MAX_NODES(MAX_NODES), .IW(IW), .CW(CW), .EW(EW)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (w_in_ready),
        .i_end_a      (i_in.end_a),
        .i_end_b      (i_in.end_b),
        .i_last       (i_in.last_edge),
        .i_out_busy   (r_out_valid),
        .o_done       (w_done),
        .o_result     (w_result),
        .o_nd_wr_en   (w_nd_wr_en),
        .o_nd_wr_addr (w_nd_wr_addr),
        .o_nd_wr_data (w_nd_wr_data),
        .o_nd_rd_addr (w_nd_rd_addr),
        .i_nd_rd_data (w_nd_rd_data),
        .o_q_wr_en    (w_q_wr_en),
        .o_q_wr_addr  (w_q_wr_addr),
        .o_q_wr_data  (w_q_wr_data),
        .o_q_rd_addr  (w_q_rd_addr),
        .i_q_rd_data  (w_q_rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.splittable = r_out.splittable;
    assign o_out.fail_cause = r_out.cause;

    // a new answer never lands on a pending one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_out_valid)
        else $error("answer overwrote pending answer");

    // splittable only with no failure cause
    a_flag_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.splittable == (r_out.cause == CAUSE_NONE)))
        else $error("splittable disagrees with cause");

    // output only rises from a handed-off answer
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_done))
        else $error("output valid without answer");

endmodule

`default_nettype wire

// ----- rtl/dlbc_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dlbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/dlbc_ctrl.sv -----
// Sequencer: edge loading by read-modify-write of the node RAM, decision,
// breadth-first two-coloring walk and clearing pass. Depends on dlbc_pkg.
`default_nettype none

module dlbc_ctrl #(
    parameter int MAX_NODES = dlbc_pkg::C_MAX_NODES,
    parameter int IW        = $clog2(MAX_NODES),
    parameter int CW        = $clog2(MAX_NODES + 1),
    parameter int EW        = 2 * IW + 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // edge requests
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [dlbc_pkg::C_END_W-1:0]  i_end_a,
    input  wire logic [dlbc_pkg::C_END_W-1:0]  i_end_b,
    input  wire logic                          i_last,
    // answer hand-off
    input  wire logic                          i_out_busy,
    output logic                               o_done,
    output dlbc_pkg::t_result                  o_result,
    // node RAM: {nbr1, nbr0, color, degree}
    output logic                               o_nd_wr_en,
    output logic [IW-1:0]                      o_nd_wr_addr,
    output logic [EW-1:0]                      o_nd_wr_data,
    output logic [IW-1:0]                      o_nd_rd_addr,
    input  wire logic [EW-1:0]                 i_nd_rd_data,
    // visit queue RAM
    output logic                               o_q_wr_en,
    output logic [IW-1:0]                      o_q_wr_addr,
    output logic [IW-1:0]                      o_q_wr_data,
    output logic [IW-1:0]                      o_q_rd_addr,
    input  wire logic [IW-1:0]                 i_q_rd_data
);

    import dlbc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LDA, S_LDB, S_DECIDE, S_SRC_RD, S_SRC_CHK,
        S_Q_RD, S_Q_WAIT, S_U_CHK, S_V_RD, S_V_CHK, S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_a, n_a, r_b, n_b;
    logic            r_last, n_last;
    logic [CW-1:0]   r_edge_total, n_edge_total;
    logic [IW-1:0]   r_high, n_high;
    logic            r_over, n_over, r_range, n_range;
    logic [CW-1:0]   r_src, n_src, r_head, n_head, r_tail, n_tail;
    logic [1:0]      r_ucol, n_ucol, r_udeg, n_udeg, r_k, n_k;
    logic [IW-1:0]   r_n0, n_n0, r_n1, n_n1, r_v, n_v;
    logic [IW-1:0]   r_clr, n_clr, r_clr_end, n_clr_end;
    t_cause          r_cause, n_cause;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    // endpoint resized to node index width
    function automatic logic [IW-1:0] f_idx(input logic [C_END_W-1:0] e);
        logic [IW-1:0] r;
        r = '0;
        for (int i = 0; i < IW; i++) begin
            r[i] = (i < C_END_W) ? e[i] : 1'b0;
        end
        return r;
    endfunction

    // append one neighbor; degree saturates at three
    function automatic logic [EW-1:0] f_add(input logic [EW-1:0] e,
                                           input logic [IW-1:0] o);
        logic [EW-1:0] r;
        r = e;
        if (e[1:0] == 2'd0) begin
            r[IW+3:4] = o;
        end else if (e[1:0] == 2'd1) begin
            r[2*IW+3:IW+4] = o;
        end
        if (e[1:0] != 2'd3) begin
            r[1:0] = e[1:0] + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [EW-1:0] f_set_col(input logic [EW-1:0] e,
                                               input logic [1:0] c);
        logic [EW-1:0] r;
        r = e;
        r[3:2] = c;
        return r;
    endfunction

    logic          w_accept;
    logic          w_ok;
    logic [IW-1:0] w_ia, w_ib;
    logic [EW-1:0] w_e1, w_e2;
    logic [CW-1:0] w_src_nx;
    logic [CW-1:0] w_last_node;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ia       = f_idx(i_end_a);
    assign w_ib       = f_idx(i_end_b);
    assign w_ok       = (32'(r_edge_total) < MAX_NODES) && (32'(i_end_a) < MAX_NODES)
                        && (32'(i_end_b) < MAX_NODES);
    assign w_src_nx   = r_src + 1'b1;
    // last node of the set; the walk may color nodes up to here
    assign w_last_node = r_edge_total - 1'b1;

    // next-state and RAM port logic
    always_comb begin
        n_state = r_state;   n_a = r_a;         n_b = r_b;       n_last = r_last;
        n_edge_total = r_edge_total;            n_high = r_high;
        n_over = r_over;     n_range = r_range; n_src = r_src;
        n_head = r_head;     n_tail = r_tail;   n_ucol = r_ucol; n_udeg = r_udeg;
        n_k = r_k;           n_n0 = r_n0;       n_n1 = r_n1;     n_v = r_v;
        n_clr = r_clr;       n_clr_end = r_clr_end;
        n_cause = r_cause;   n_done = 1'b0;     n_res = r_res;
        o_nd_wr_en = 1'b0;   o_nd_wr_addr = '0; o_nd_wr_data = '0; o_nd_rd_addr = '0;
        o_q_wr_en = 1'b0;    o_q_wr_addr = '0;  o_q_wr_data = '0;  o_q_rd_addr = '0;
        w_e1 = f_add(i_nd_rd_data, r_b);
        w_e2 = f_add(w_e1, r_b);

        unique case (r_state)
            // reset every node up to the clear limit
            S_CLEAR: begin
                o_nd_wr_en   = 1'b1;
                o_nd_wr_addr = r_clr;
                o_nd_wr_data = f_set_col('0, C_UNCOLOURED);
                n_clr        = r_clr + 1'b1;
                if (r_clr == r_clr_end) begin
                    n_state = S_IDLE;
                end
            end
            // take an edge request; an in-range one starts reading endpoint a, an out-of-range one sets the range flag
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_last;
                    if (w_ok) begin
                        n_edge_total = r_edge_total + 1'b1;
                        n_a          = w_ia;
                        n_b          = w_ib;
                        if (w_ia > r_high && w_ia >= w_ib) begin
                            n_high = w_ia;
                        end else if (w_ib > r_high) begin
                            n_high = w_ib;
                        end
                        o_nd_rd_addr = w_ia;
                        n_state      = S_LDA;
                    end else begin
                        n_range = 1'b1;
                        n_state = i_last ? S_DECIDE : S_IDLE;
                    end
                end
            end
            // update a; a self-loop adds the node twice
            S_LDA: begin
                o_nd_wr_en   = 1'b1;
                o_nd_wr_addr = r_a;
                if (r_a == r_b) begin
                    o_nd_wr_data = w_e2;
                    if (w_e2[1:0] == 2'd3) begin
                        n_over = 1'b1;
                    end
                    n_state = r_last ? S_DECIDE : S_IDLE;
                end else begin
                    o_nd_wr_data = w_e1;
                    if (w_e1[1:0] == 2'd3) begin
                        n_over = 1'b1;
                    end
                    o_nd_rd_addr = r_b;
                    n_state      = S_LDB;
                end
            end
            S_LDB: begin
                o_nd_wr_en   = 1'b1;
                o_nd_wr_addr = r_b;
                o_nd_wr_data = f_add(i_nd_rd_data, r_a);
                if (o_nd_wr_data[1:0] == 2'd3) begin
                    n_over = 1'b1;
                end
                n_state = r_last ? S_DECIDE : S_IDLE;
            end
            // range before degree before odd cycle
            S_DECIDE: begin
                if (r_range || (32'(r_high) >= 32'(r_edge_total))) begin
                    n_cause = CAUSE_RANGE;
                    n_state = S_FIN;
                end else if (r_over) begin
                    n_cause = CAUSE_DEGREE;
                    n_state = S_FIN;
                end else begin
                    n_src   = '0;
                    n_state = S_SRC_RD;
                end
            end
            S_SRC_RD: begin
                o_nd_rd_addr = r_src[IW-1:0];
                n_state      = S_SRC_CHK;
            end
            // uncolored source starts a new component
            S_SRC_CHK: begin
                if (i_nd_rd_data[3:2] != C_UNCOLOURED) begin
                    n_src = w_src_nx;
                    if (w_src_nx == r_edge_total) begin
                        n_cause = CAUSE_NONE;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SRC_RD;
                    end
                end else begin
                    o_nd_wr_en   = 1'b1;
                    o_nd_wr_addr = r_src[IW-1:0];
                    o_nd_wr_data = f_set_col(i_nd_rd_data, 2'd0);
                    o_q_wr_en    = 1'b1;
                    o_q_wr_addr  = '0;
                    o_q_wr_data  = r_src[IW-1:0];
                    n_head       = '0;
                    n_tail       = CW'(1);
                    n_state      = S_Q_RD;
                end
            end
            // pop next node or move to next source
            S_Q_RD: begin
                if (r_head == r_tail) begin
                    n_src = w_src_nx;
                    if (w_src_nx == r_edge_total) begin
                        n_cause = CAUSE_NONE;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SRC_RD;
                    end
                end else begin
                    o_q_rd_addr = r_head[IW-1:0];
                    n_head      = r_head + 1'b1;
                    n_state     = S_Q_WAIT;
                end
            end
            S_Q_WAIT: begin
                o_nd_rd_addr = i_q_rd_data;
                n_state      = S_U_CHK;
            end
            S_U_CHK: begin
                n_udeg  = i_nd_rd_data[1:0];
                n_ucol  = i_nd_rd_data[3:2];
                n_n0    = i_nd_rd_data[IW+3:4];
                n_n1    = i_nd_rd_data[2*IW+3:IW+4];
                n_k     = '0;
                n_state = S_V_RD;
            end
            S_V_RD: begin
                if (r_k < r_udeg) begin
                    n_v          = r_k[0] ? r_n1 : r_n0;
                    o_nd_rd_addr = n_v;
                    n_state      = S_V_CHK;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            // color and enqueue a fresh neighbor, or detect a conflict
            S_V_CHK: begin
                n_k     = r_k + 2'd1;
                n_state = S_V_RD;
                if (i_nd_rd_data[3:2] == C_UNCOLOURED) begin
                    o_nd_wr_en   = 1'b1;
                    o_nd_wr_addr = r_v;
                    o_nd_wr_data = f_set_col(i_nd_rd_data, r_ucol ^ 2'd1);
                    if (32'(r_tail) < MAX_NODES) begin
                        o_q_wr_en   = 1'b1;
                        o_q_wr_addr = r_tail[IW-1:0];
                        o_q_wr_data = r_v;
                        n_tail      = r_tail + 1'b1;
                    end
                end else if (i_nd_rd_data[3:2] == r_ucol) begin
                    n_cause = CAUSE_ODD;
                    n_state = S_FIN;
                end
            end
            // hand off answer, then clear every touched or colored node
            S_FIN: begin
                if (!i_out_busy) begin
                    n_done           = 1'b1;
                    n_res.splittable = (r_cause == CAUSE_NONE);
                    n_res.cause      = r_cause;
                    n_clr            = '0;
                    if ((r_edge_total != '0) && (w_last_node[IW-1:0] > r_high)) begin
                        n_clr_end = w_last_node[IW-1:0];
                    end else begin
                        n_clr_end = r_high;
                    end
                    n_edge_total     = '0;
                    n_high           = '0;
                    n_over           = 1'b0;
                    n_range          = 1'b0;
                    n_state          = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_clr_end    <= IW'(MAX_NODES - 1);
            r_edge_total <= '0;
            r_high       <= '0;
            r_over       <= 1'b0;
            r_range      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_clr_end    <= n_clr_end;
            r_edge_total <= n_edge_total;
            r_high       <= n_high;
            r_over       <= n_over;
            r_range      <= n_range;
            r_done       <= n_done;
        end
        r_a <= n_a;         r_b <= n_b;         r_last <= n_last;
        r_src <= n_src;     r_head <= n_head;   r_tail <= n_tail;
        r_ucol <= n_ucol;   r_udeg <= n_udeg;   r_k <= n_k;
        r_n0 <= n_n0;       r_n1 <= n_n1;       r_v <= n_v;
        r_cause <= n_cause; r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the degree-limited bipartite check unit: drives edge sets,
// predicts each answer in a local model and compares it with o_out.
// Depends on dlbc_pkg, dlbc_if and the unit's RTL.
`default_nettype none

module tb;
    import dlbc_pkg::*;

    localparam int NODES = C_MAX_NODES;
    localparam int LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors;
    bit   idle_on;
    bit   hold_req;
    int   sets_sent;

    dlbc_in_if  i_in ();
    dlbc_out_if o_out ();

    degree_limited_bipartite_check_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in.sink),
        .o_out   (o_out.source)
    );

    // Model state for the set being loaded
    logic [9:0] nbr [2*NODES];
    logic [1:0] deg [NODES];
    int         edge_cnt;
    int         top_idx;
    bit         deg_err;
    bit         rng_err;
    t_result    answers_due [$];

    function automatic void clear_model();
        for (int i = 0; i < NODES; i++) deg[i] = 0;
        edge_cnt = 0;
        top_idx  = 0;
        deg_err  = 0;
        rng_err  = 0;
    endfunction

    function automatic void link_node(int n, int o);
        if (deg[n] < 2) nbr[2*n+deg[n]] = o[9:0];
        if (deg[n] < 3) deg[n] = deg[n] + 1;
        if (deg[n] > 2) deg_err = 1;
    endfunction

    // Breadth-first two-coloring; returns 1 on a conflicting neighbor
    function automatic bit has_odd_cycle(int n);
        logic [1:0] col [NODES];
        int q [NODES];
        int head, tail, u, v;
        for (int i = 0; i < NODES; i++) col[i] = C_UNCOLOURED;
        for (int s = 0; s < n; s++) begin
            if (col[s] == C_UNCOLOURED) begin
                head = 0; tail = 0;
                col[s] = 0;
                q[tail++] = s;
                while (head < tail) begin
                    u = q[head++];
                    for (int k = 0; k < deg[u] && k < 2; k++) begin
                        v = nbr[2*u+k];
                        if (col[v] == C_UNCOLOURED) begin
                            col[v] = col[u] ^ 2'd1;
                            q[tail++] = v;
                        end else if (col[v] == col[u]) begin
                            return 1;
                        end
                    end
                end
            end
        end
        return 0;
    endfunction

    // Apply one accepted edge to the model
    function automatic void predict_edge(int a, int b, bit last);
        t_result r;
        t_cause  c;
        if (edge_cnt >= NODES) begin
            rng_err = 1;
        end else begin
            edge_cnt++;
            if (a > top_idx) top_idx = a;
            if (b > top_idx) top_idx = b;
            link_node(a, b);
            link_node(b, a);
        end
        if (last) begin
            if (rng_err || top_idx >= edge_cnt) c = CAUSE_RANGE;
            else if (deg_err)                   c = CAUSE_DEGREE;
            else if (has_odd_cycle(edge_cnt))   c = CAUSE_ODD;
            else                                c = CAUSE_NONE;
            r.splittable = (c == CAUSE_NONE);
            r.cause      = c;
            answers_due.insert(answers_due.size(), r);
            clear_model();
        end
    endfunction

    // Clock and cycle limit
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL degree_limited_bipartite_check_unit");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold when requested
    initial begin
        int gap;
        o_out.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                o_out.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 3);
                o_out.ready <= 0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                o_out.ready <= 1;
            end
        end
    end

    // Answer checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out.valid && o_out.ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected answer %b/%0d", $time,
                         o_out.splittable, o_out.fail_cause);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (o_out.splittable !== want.splittable ||
                    o_out.fail_cause !== want.cause) begin
                    $display("%0t: expected %b/%0d got %b/%0d", $time,
                             want.splittable, want.cause,
                             o_out.splittable, o_out.fail_cause);
                    errors++;
                end
            end
        end
    end

    // Send one edge request, with an optional idle burst first;
    // valid stays high after acceptance until the next request or a stop
    task automatic send_edge(int a, int b, bit last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in.valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in.valid     <= 1;
        i_in.end_a     <= a[9:0];
        i_in.end_b     <= b[9:0];
        i_in.last_edge <= last;
        @(posedge i_clk);
        while (!i_in.ready) @(posedge i_clk);
        predict_edge(a, b, last);
        if (last) sets_sent++;
    endtask

    // Drop valid once a run of requests is over
    task automatic stop_input();
        i_in.valid <= 0;
        @(posedge i_clk);
    endtask

    // Path or cycle over nodes 0..n-1 with shuffled labels
    task automatic send_ring(int n, bit closed);
        int lab [];
        int k, t;
        lab = new[n];
        for (int i = 0; i < n; i++) lab[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = lab[i]; lab[i] = lab[k]; lab[k] = t;
        end
        // n edges: path of n-1 plus a closing or self edge
        for (int i = 0; i < n - 1; i++)
            send_edge(lab[i], lab[i+1], 0);
        if (closed) send_edge(lab[n-1], lab[0], 1);
        else send_edge(lab[n-1], lab[n-1], 1);
    endtask

    task automatic test_directed();
        send_edge(0, 0, 1);            // self-loop
        send_edge(0, 1, 0); send_edge(1, 0, 1);  // even cycle of 2
        send_edge(0, 1, 0); send_edge(1, 2, 0); send_edge(2, 0, 1); // odd
        send_edge(0, 1, 0); send_edge(0, 2, 0); send_edge(0, 3, 0);
        send_edge(2, 3, 1);            // degree above two
        send_edge(1023, 0, 1);         // index beyond edge count
        send_edge(0, 1, 1);            // index equals edge count
        send_edge(1023, 1023, 0); send_edge(682, 341, 1);
        send_edge(0, 1, 0); send_edge(2, 3, 0); send_edge(0, 3, 0);
        send_edge(1, 2, 1);            // even cycle of 4
    endtask

    task automatic test_random();
        int n, pick;
        while (sets_sent < 75) begin
            pick = $urandom_range(0, 9);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 60)
                                             : $urandom_range(2, 10);
            if (pick < 4) send_ring(n, 1);
            else if (pick < 6) send_ring(n, 0);
            else if (pick < 8) begin
                for (int i = 0; i < n; i++)
                    send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              i == n - 1);
            end else begin
                for (int i = 0; i < n; i++)
                    send_edge($urandom_range(0, 1023), $urandom_range(0, 1023),
                              i == n - 1);
            end
        end
    endtask

    // Overfull set: more edges than capacity
    task automatic test_overflow();
        for (int i = 0; i < NODES + 2; i++)
            send_edge(i % NODES, (i + 1) % NODES, i == NODES + 1);
    endtask

    // Long output stall while sets keep loading
    task automatic test_backpressure();
        hold_req = 1;
        repeat (6) send_ring(4, 1);
        stop_input();
        while (hold_req) @(posedge i_clk);
    endtask

    initial begin
        int drain;
        cycles = 0; errors = 0; sets_sent = 0;
        idle_on = 1; hold_req = 0;
        clear_model();
        i_rst_n <= 0;
        i_in.valid <= 0; i_in.end_a <= 0; i_in.end_b <= 0; i_in.last_edge <= 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_backpressure();
        test_overflow();
        test_random();
        idle_on = 0;
        repeat (8) send_ring(5, 1);
        stop_input();
        drain = 0;
        while (answers_due.size() != 0) @(posedge i_clk);
        while (drain < 3000) begin
            @(posedge i_clk);
            drain++;
        end
        if (errors == 0 && answers_due.size() == 0)
            $display("PASS degree_limited_bipartite_check_unit");
        else
            $display("FAIL degree_limited_bipartite_check_unit");
        $finish;
    end
endmodule

`default_nettype wire

// ----- degree_limited_bipartite_check_unit.f -----
rtl/dlbc_pkg.sv
rtl/dlbc_if.sv
rtl/dlbc_ram.sv
rtl/dlbc_ctrl.sv
rtl/degree_limited_bipartite_check_unit.sv
dv/tb.sv
